/* rtl/timestamp_table_binary_search_defines.svh */
// ----------------------------------------------------------------------------
// Timestamp table search - assertion macros
// Shared property macros for the checker, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_TABLE_BINARY_SEARCH_DEFINES_SVH
`define TIMESTAMP_TABLE_BINARY_SEARCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsbs check failed in same cycle");

// consequent must hold in the cycle after the antecedent
`define TSBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsbs check failed in next cycle");

`endif

/* rtl/tsbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp table search package
// Sizes, word layouts, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tsbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int NUM_SENSORS = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SENS_AW     = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int CNT_ENTRIES = 1 << SENS_AW;
    localparam int RAM_DEPTH   = CNT_ENTRIES * TABLE_DEPTH;

    // field widths
    localparam int KIND_W   = 2;
    localparam int SENSOR_W = 3;
    localparam int TIME_W   = 44;
    localparam int POS_W    = 12;
    localparam int AFTER_W  = 13;
    localparam int LIMIT_W  = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd200;

    // input word layout
    localparam int S_TDATA_W    = 48;
    localparam int S_SENSOR_LSB = 0;
    localparam int S_TIME_LSB   = S_SENSOR_LSB + SENSOR_W;

    // result word layout
    localparam int M_TDATA_W   = 32;
    localparam int M_FOUND_BIT = 0;
    localparam int M_POS_LSB   = 1;
    localparam int M_AFTER_LSB = M_POS_LSB + POS_W;
    localparam int M_FULL_BIT  = M_AFTER_LSB + AFTER_W;
    localparam int M_PAD_W     = M_TDATA_W - M_FULL_BIT - 1;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    // memory address source
    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_MID,
        ADDR_APPEND
    } addr_sel_t;

    // result register update
    typedef enum logic [2:0] {
        RES_KEEP,
        RES_NONE,
        RES_HIT_FIRST,
        RES_HIT_MID,
        RES_FULL
    } res_op_t;

    typedef struct packed {
        logic      load_item;
        logic      ram_rd;
        addr_sel_t addr_sel;
        logic      do_append;
        logic      do_clear;
        logic      init_range;
        logic      set_mid;
        logic      step;
        res_op_t   res_op;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  sensor_ok;
        logic  time_zero;
        logic  cnt_le1;
        logic  tbl_full;
        logic  range_ok;
        logic  data_ge;
        logic  data_eq;
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/tsbs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module tsbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and read register
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/tsbs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp table search - controller
// Sequences append, clear and the halving search, and owns the output valid.
// ----------------------------------------------------------------------------
module tsbs_ctrl
    import tsbs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.sensor_ok && status.kind == KIND_SEARCH &&
                    !status.time_zero && !status.cnt_le1) begin
                    state_next = ST_CHK_FIRST;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHK_FIRST: begin
                state_next = status.data_ge ? ST_FINISH : ST_CHK_LAST;
            end
            ST_CHK_LAST: begin
                state_next = status.data_ge ? ST_PROBE : ST_FINISH;
            end
            ST_PROBE: begin
                state_next = status.range_ok ? ST_COMPARE : ST_FINISH;
            end
            ST_COMPARE: begin
                state_next = status.data_eq ? ST_FINISH : ST_PROBE;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_DECODE: begin
                cmd.res_op = RES_NONE;
                if (status.sensor_ok) begin
                    case (status.kind)
                        KIND_APPEND: begin
                            if (status.tbl_full) begin
                                cmd.res_op = RES_FULL;
                            end else begin
                                cmd.do_append = 1'b1;
                                cmd.addr_sel  = ADDR_APPEND;
                            end
                        end
                        KIND_CLEAR: begin
                            cmd.do_clear = 1'b1;
                        end
                        KIND_SEARCH: begin
                            if (status.time_zero) begin
                                cmd.res_op = RES_HIT_FIRST;
                            end else if (!status.cnt_le1) begin
                                cmd.ram_rd   = 1'b1;
                                cmd.addr_sel = ADDR_FIRST;
                            end
                        end
                        default: begin
                            cmd.res_op = RES_NONE;
                        end
                    endcase
                end
            end
            ST_CHK_FIRST: begin
                if (status.data_ge) begin
                    cmd.res_op = RES_HIT_FIRST;
                end else begin
                    cmd.ram_rd   = 1'b1;
                    cmd.addr_sel = ADDR_LAST;
                end
            end
            ST_CHK_LAST: begin
                if (status.data_ge) begin
                    cmd.init_range = 1'b1;
                end else begin
                    cmd.res_op = RES_NONE;
                end
            end
            ST_PROBE: begin
                if (status.range_ok) begin
                    cmd.ram_rd   = 1'b1;
                    cmd.addr_sel = ADDR_MID;
                    cmd.set_mid  = 1'b1;
                end else begin
                    cmd.res_op = RES_NONE;
                end
            end
            ST_COMPARE: begin
                if (status.data_eq) begin
                    cmd.res_op = RES_HIT_MID;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.out_load = !out_valid_reg || m_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // result word valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/tsbs_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp table search - datapath
// Item registers, fill counts, timestamp memory, search bounds and result word.
// ----------------------------------------------------------------------------
module tsbs_dpath
    import tsbs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [KIND_W-1:0]    s_tuser,
    input  wire logic                 cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]   cfg_wr_data,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int RAM_AW = SENS_AW + IDX_W;

    logic [KIND_W-1:0]    kind_reg;
    logic [SENSOR_W-1:0]  sensor_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [CNT_W-1:0]     count_reg [CNT_ENTRIES];
    logic [CNT_W-1:0]     count_next [CNT_ENTRIES];
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hip1_reg;
    logic [IDX_W-1:0]     mid_reg;
    logic                 res_found_reg;
    logic [IDX_W-1:0]     res_pos_reg;
    logic                 res_full_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [SENS_AW-1:0]   sidx;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid_calc;
    logic [RAM_AW-1:0]    ram_addr;
    logic [TIME_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]     pos_ext;
    logic [CNT_W-1:0]     tail_cnt;
    logic [AFTER_W-1:0]   after_raw;
    logic [AFTER_W-1:0]   after_val;

    assign sidx    = SENS_AW'(sensor_reg);
    assign cur_cnt = count_reg[sidx];

    // accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg   <= s_tuser;
            sensor_reg <= s_tdata[S_SENSOR_LSB +: SENSOR_W];
            time_reg   <= s_tdata[S_TIME_LSB +: TIME_W];
        end
    end

    // report limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // fill counts
    always_comb begin
        count_next = count_reg;
        if (cmd.do_append) begin
            count_next[sidx] = cur_cnt + 1'b1;
        end else if (cmd.do_clear) begin
            count_next[sidx] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CNT_ENTRIES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
        end
    end

    // midpoint of the open range, lo below hi plus one
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hip1_reg} - 1'b1;
    assign mid_calc = mid_sum[IDX_W:1];

    // search bounds
    always_ff @(posedge aclk) begin
        if (cmd.init_range) begin
            lo_reg   <= '0;
            hip1_reg <= cur_cnt;
        end else if (cmd.step) begin
            if (!status.data_ge) begin
                lo_reg <= CNT_W'(mid_reg) + 1'b1;
            end else begin
                hip1_reg <= CNT_W'(mid_reg);
            end
        end
        if (cmd.set_mid) begin
            mid_reg <= mid_calc;
        end
    end

    // memory address select
    always_comb begin
        case (cmd.addr_sel)
            ADDR_FIRST:  ram_addr = {sidx, {IDX_W{1'b0}}};
            ADDR_LAST:   ram_addr = {sidx, IDX_W'(cur_cnt - 1'b1)};
            ADDR_MID:    ram_addr = {sidx, mid_calc};
            ADDR_APPEND: ram_addr = {sidx, cur_cnt[IDX_W-1:0]};
            default:     ram_addr = {sidx, {IDX_W{1'b0}}};
        endcase
    end

    tsbs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (cmd.ram_rd || cmd.do_append),
        .we    (cmd.do_append),
        .addr  (ram_addr),
        .wdata (time_reg),
        .rdata (ram_rdata)
    );

    // status to the controller
    always_comb begin
        status.kind      = kind_t'(kind_reg);
        status.sensor_ok = int'(sensor_reg) < NUM_SENSORS;
        status.time_zero = time_reg == '0;
        status.cnt_le1   = cur_cnt <= CNT_W'(1);
        status.tbl_full  = int'(cur_cnt) >= TABLE_DEPTH;
        status.range_ok  = lo_reg < hip1_reg;
        status.data_ge   = ram_rdata >= time_reg;
        status.data_eq   = ram_rdata == time_reg;
    end

    // result registers
    always_ff @(posedge aclk) begin
        case (cmd.res_op)
            RES_NONE: begin
                res_found_reg <= 1'b0;
                res_pos_reg   <= '0;
                res_full_reg  <= 1'b0;
            end
            RES_HIT_FIRST: begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= '0;
                res_full_reg  <= 1'b0;
            end
            RES_HIT_MID: begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= mid_reg;
                res_full_reg  <= 1'b0;
            end
            RES_FULL: begin
                res_found_reg <= 1'b0;
                res_pos_reg   <= '0;
                res_full_reg  <= 1'b1;
            end
            default: begin
                res_found_reg <= res_found_reg;
            end
        endcase
    end

    // entries after the match, floored at zero and capped by the limit
    assign pos_ext  = CNT_W'(res_pos_reg);
    assign tail_cnt = cur_cnt - pos_ext - 1'b1;
    assign after_raw = (res_found_reg && cur_cnt > pos_ext + 1'b1) ?
                       AFTER_W'(tail_cnt) : '0;
    assign after_val = (after_raw > AFTER_W'(limit_reg)) ? AFTER_W'(limit_reg) : after_raw;

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {{M_PAD_W{1'b0}}, res_full_reg, after_val,
                             POS_W'(res_pos_reg), res_found_reg};
        end
    end

    assign m_tdata = out_data_reg;

endmodule
`default_nettype wire

/* rtl/timestamp_table_binary_search.sv */
// Append, clear and trivial searches pass through DECODE and FINISH to the registered result word.
// Other searches also check the first and last entries, then take at most 13 halving steps,
// each a PROBE and a COMPARE state, as each step waits on one registered read of the single-port timestamp memory.
// One word is in work at a time: the next is accepted once the controller is back in idle,
// after the result word is registered; a stalled result word holds the controller in FINISH.
// Reset: fill counts cleared, report_limit set to 200; the memory itself is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp table search - top level
// Per-sensor ascending timestamp tables with append, clear and exact or first-entry search.
// ----------------------------------------------------------------------------
module timestamp_table_binary_search
    import tsbs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,    // sensor_id[2:0], time_value[46:3]
    input  wire logic [KIND_W-1:0]    s_tuser,    // kind[1:0]
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,    // found[0], position[12:1],
                                                  // entries_after[25:13], table_full[26]
    // report limit register
    input  wire logic                 cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]   cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    tsbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, bounds and result word
    tsbs_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

/* rtl/tsbs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp table search - port checker
// Watches the top-level ports and checks ordering and result word sanity.
// ----------------------------------------------------------------------------
`include "timestamp_table_binary_search_defines.svh"

module tsbs_checker
    import tsbs_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       miss_clean;

    // words accepted but not yet delivered
    assign pend_next = pend_reg + {1'b0, s_tvalid && s_tready} - {1'b0, m_tvalid && m_tready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // position and following entries both zero
    assign miss_clean = (m_tdata[M_POS_LSB +: POS_W] == '0) &&
                        (m_tdata[M_AFTER_LSB +: AFTER_W] == '0);

    // a stalled result word holds
    `TSBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a result word always belongs to an accepted word
    `TSBS_ASSERT_SAME(a_out_owned, m_tvalid, pend_reg != 2'd0)

    // one word in work at a time
    `TSBS_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

    // a miss carries no position and no following entries
    `TSBS_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tdata[M_FOUND_BIT], miss_clean)

    // a dropped append never reports a match
    `TSBS_ASSERT_SAME(a_full_no_hit, m_tvalid && m_tdata[M_FULL_BIT], !m_tdata[M_FOUND_BIT])

endmodule

bind timestamp_table_binary_search tsbs_checker u_checker (.*);
`default_nettype wire
